// ===== hdl/swbm_pkg.sv =====
package swbm_pkg;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_RX   = 3'd1;
  localparam logic [2:0] OP_LOAD = 3'd2;
  localparam logic [2:0] OP_SEND = 3'd3;
  localparam logic [2:0] OP_RECV = 3'd4;

  localparam logic [1:0] CFG_BREAK   = 2'd0;
  localparam logic [1:0] CFG_PAUSE   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [11:0] BREAK_RESET   = 12'd677;
  localparam logic [11:0] PAUSE_RESET   = 12'd26;
  localparam logic [11:0] TIMEOUT_RESET = 12'd1041;

  localparam logic [11:0] CNT_MAX   = 12'hFFF;
  localparam logic [7:0]  SYNC_BYTE = 8'h55;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BREAK = 3'd1,
    PH_PAUSE = 3'd2,
    PH_SYNC  = 3'd3,
    PH_XFER  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       line_high;
    logic [6:0] length;
  } item_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [5:0] rx_index;
    logic [7:0] rx_byte;
    logic       send_done;
    logic       receive_done;
    logic [6:0] rx_count;
    phase_t     bus_phase;
    logic       uart_fast;
  } result_t;

  typedef struct packed {
    logic [11:0] break_ticks;
    logic [11:0] pause_ticks;
    logic [11:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== hdl/swbm_txbuf.sv =====
module swbm_txbuf #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/swbm_core.sv =====
module swbm_core import swbm_pkg::*; #(
  parameter int BUFFER_DEPTH = 64,
  parameter int IW           = 6,
  parameter int PW           = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  item_t         item,
  input  logic [7:0]    rdata,
  input  logic          commit,
  output result_t       res,
  output logic [IW-1:0] rd_addr
);

  typedef enum logic [1:0] {
    TXS_IDLE, TXS_PENDING, TXS_ACTIVE, TXS_END
  } send_t;

  typedef enum logic [1:0] {
    RXS_IDLE, RXS_PENDING, RXS_ACTIVE
  } recv_t;

  phase_t        phase, phase_next;
  logic [11:0]   timer_count, timer_count_next;
  logic          timer_running, timer_running_next;
  send_t         send_status, send_status_next;
  recv_t         receive_status, receive_status_next;
  logic [PW-1:0] tx_length, tx_length_next;
  logic [PW-1:0] tx_position, tx_position_next;
  logic [7:0]    last_sent, last_sent_next;
  logic [PW-1:0] rx_limit, rx_limit_next;
  logic [PW-1:0] rx_position, rx_position_next;

  logic [11:0]   count_inc;
  logic [11:0]   target;
  logic [PW-1:0] len_clamped;
  phase_t        phase_eff;
  logic [PW-1:0] pos_eff;

  assign count_inc   = (timer_count == CNT_MAX) ? timer_count : timer_count + 12'd1;
  assign len_clamped = (int'(item.length) > BUFFER_DEPTH) ? PW'(BUFFER_DEPTH)
                                                          : PW'(item.length);

  always_comb begin
    case (phase)
      PH_BREAK: target = cfg.break_ticks;
      PH_PAUSE: target = cfg.pause_ticks;
      default:  target = cfg.timeout_ticks;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    timer_count_next    = timer_count;
    timer_running_next  = timer_running;
    send_status_next    = send_status;
    receive_status_next = receive_status;
    tx_length_next      = tx_length;
    tx_position_next    = tx_position;
    last_sent_next      = last_sent;
    rx_limit_next       = rx_limit;
    rx_position_next    = rx_position;
    res                 = '0;

    case (item.op)
      OP_TICK: begin
        if (timer_running) begin
          if (count_inc >= target) begin
            timer_count_next = '0;
            case (phase)
              PH_BREAK: phase_next = PH_PAUSE;
              PH_PAUSE: begin
                phase_next   = PH_SYNC;
                res.tx_valid = 1'b1;
                res.tx_byte  = SYNC_BYTE;
              end
              default: begin
                timer_running_next = 1'b0;
                phase_next         = PH_IDLE;
                if (send_status == TXS_END) begin
                  send_status_next = TXS_IDLE;
                  res.send_done    = 1'b1;
                end else if (receive_status == RXS_ACTIVE) begin
                  receive_status_next = RXS_IDLE;
                  res.receive_done    = 1'b1;
                  res.rx_count        = 7'(rx_position);
                end
              end
            endcase
          end else begin
            timer_count_next = count_inc;
          end
        end
      end
      OP_RX: begin
        case (phase)
          PH_IDLE: begin
            timer_count_next   = '0;
            timer_running_next = 1'b1;
            phase_next         = PH_BREAK;
          end
          PH_SYNC: begin
            timer_count_next = '0;
            if (item.data_byte != SYNC_BYTE) begin
              timer_running_next = 1'b1;
              phase_next         = PH_BREAK;
            end else begin
              if (receive_status != RXS_IDLE) begin
                receive_status_next = RXS_ACTIVE;
                rx_position_next    = '0;
              end
              if (send_status != TXS_IDLE) begin
                send_status_next = TXS_ACTIVE;
                last_sent_next   = rdata;
                tx_position_next = PW'(1);
                res.tx_valid     = 1'b1;
                res.tx_byte      = rdata;
              end
              phase_next = PH_XFER;
            end
          end
          PH_XFER: begin
            timer_count_next = '0;
            if (send_status == TXS_ACTIVE) begin
              if (item.data_byte == last_sent && item.line_high) begin
                if (tx_position < tx_length) begin
                  last_sent_next   = rdata;
                  tx_position_next = tx_position + PW'(1);
                  res.tx_valid     = 1'b1;
                  res.tx_byte      = rdata;
                end else begin
                  send_status_next = TXS_END;
                end
              end else begin
                send_status_next = TXS_PENDING;
              end
            end else if (send_status == TXS_END) begin
              send_status_next = TXS_PENDING;
            end
            if (receive_status == RXS_ACTIVE && rx_position < rx_limit) begin
              res.rx_valid     = 1'b1;
              res.rx_index     = 6'(rx_position);
              res.rx_byte      = item.data_byte;
              rx_position_next = rx_position + PW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      OP_SEND: begin
        if (item.length != 7'd0 && send_status == TXS_IDLE) begin
          send_status_next   = TXS_PENDING;
          tx_length_next     = len_clamped;
          tx_position_next   = '0;
          timer_count_next   = '0;
          timer_running_next = 1'b1;
          phase_next         = PH_BREAK;
        end
      end
      OP_RECV: begin
        if (receive_status == RXS_IDLE) begin
          receive_status_next = RXS_PENDING;
          rx_limit_next       = len_clamped;
          rx_position_next    = '0;
        end
      end
      default: begin
      end
    endcase

    res.tx_line   = (phase_next != PH_BREAK);
    res.uart_fast = (phase_next == PH_BREAK) || (phase_next == PH_PAUSE);
    res.bus_phase = phase_next;
  end

  // The next item's buffer read is aimed at the state this item leaves behind.
  assign phase_eff = commit ? phase_next : phase;
  assign pos_eff   = commit ? tx_position_next : tx_position;
  assign rd_addr   = (phase_eff == PH_SYNC) ? '0 : IW'(pos_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      timer_count    <= '0;
      timer_running  <= 1'b0;
      send_status    <= TXS_IDLE;
      receive_status <= RXS_IDLE;
      tx_length      <= '0;
      tx_position    <= '0;
      last_sent      <= '0;
      rx_limit       <= '0;
      rx_position    <= '0;
    end else if (commit) begin
      phase          <= phase_next;
      timer_count    <= timer_count_next;
      timer_running  <= timer_running_next;
      send_status    <= send_status_next;
      receive_status <= receive_status_next;
      tx_length      <= tx_length_next;
      tx_position    <= tx_position_next;
      last_sent      <= last_sent_next;
      rx_limit       <= rx_limit_next;
      rx_position    <= rx_position_next;
    end
  end

endmodule

// ===== hdl/single_wire_bus_master_sequencer.sv =====
// Bus master sequencer for a single-wire half-duplex UART bus. Each input item is
// one event: a tick, a received byte with the line level, a transmit-buffer load,
// a send request or a receive request. Each item yields exactly one result item
// describing the line level, the byte handed to the transmitter, the byte to store,
// completion flags and the bus phase. The block takes one item per clock cycle
// while the output is not stalled. The transmit buffer is a synchronous memory
// whose registered read is issued as an item is accepted, with the read address
// steered by the state the previous item leaves behind; the item waits in a first
// stage for that read, and its result is then held in the output register.
// Buffer loads are written at acceptance, so a load followed at once by a send
// reads back correctly. Timing registers (break, pause, timeout, in ticks) are
// to be written through the configuration port only while the block is idle;
// the block itself does not enforce this. Reset restores 677, 26 and 1041.
// Buffer entries are undefined until loaded.
module single_wire_bus_master_sequencer import swbm_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  data_byte,
  input  logic        line_high,
  input  logic [5:0]  load_index,
  input  logic [6:0]  length,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_line,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        rx_valid,
  output logic [5:0]  rx_index,
  output logic [7:0]  rx_byte,
  output logic        send_done,
  output logic        receive_done,
  output logic [6:0]  rx_count,
  output logic [2:0]  bus_phase,
  output logic        uart_fast
);

  localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  cfg_t          cfg;
  item_t         s1_item;
  logic          s1_valid;
  logic          s1_adv;
  logic          in_accept;
  logic          load_we;
  logic [7:0]    rdata;
  logic [IW-1:0] rd_addr;
  result_t       res;
  result_t       out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.break_ticks   <= BREAK_RESET;
      cfg.pause_ticks   <= PAUSE_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BREAK:   cfg.break_ticks   <= cfg_data;
        CFG_PAUSE:   cfg.pause_ticks   <= cfg_data;
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The item in the first stage is processed once the output register can take
  // its result; a new item enters whenever the first stage empties or moves on.
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Loads beyond the buffer are dropped.
  assign load_we = in_accept && (op == OP_LOAD) && (int'(load_index) < BUFFER_DEPTH);

  swbm_txbuf #(
    .DEPTH (BUFFER_DEPTH),
    .IW    (IW)
  ) u_txbuf (
    .clk   (clk),
    .we    (load_we),
    .waddr (IW'(load_index)),
    .wdata (data_byte),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  swbm_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .IW           (IW),
    .PW           (PW)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (s1_item),
    .rdata   (rdata),
    .commit  (s1_adv),
    .res     (res),
    .rd_addr (rd_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.op        <= op;
      s1_item.data_byte <= data_byte;
      s1_item.line_high <= line_high;
      s1_item.length    <= length;
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= res;
    end
  end

  assign tx_line      = out_res.tx_line;
  assign tx_valid     = out_res.tx_valid;
  assign tx_byte      = out_res.tx_byte;
  assign rx_valid     = out_res.rx_valid;
  assign rx_index     = out_res.rx_index;
  assign rx_byte      = out_res.rx_byte;
  assign send_done    = out_res.send_done;
  assign receive_done = out_res.receive_done;
  assign rx_count     = out_res.rx_count;
  assign bus_phase    = out_res.bus_phase;
  assign uart_fast    = out_res.uart_fast;

  // A first-stage item that cannot move on keeps its payload.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_item)))
    else $error("first stage item lost or changed while blocked");

  // Accepting into an occupied first stage requires that stage to move on.
  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s1_valid) |-> s1_adv)
    else $error("first stage overwritten");

  // The line is low exactly in the break phase.
  a_line_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_line == (out_res.bus_phase != PH_BREAK)))
    else $error("tx_line disagrees with bus phase");

  // A byte goes to the transmitter only on entering sync or within a transfer.
  a_tx_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_valid) |->
      (out_res.bus_phase == PH_SYNC || out_res.bus_phase == PH_XFER))
    else $error("transmit byte outside sync or transfer");

  // A timeout ends either a send or a receive, never both.
  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(send_done && receive_done))
    else $error("send and receive completed together");

endmodule
